// File: rtl/core/sldag_pkg.sv
// Shared types and constants of the sine line-distortion address generator.
package sldag_pkg;

    // Distortion modes carried in the op field of an input item.
    localparam logic [1:0] OP_HORIZONTAL = 2'd0;
    localparam logic [1:0] OP_INTERLACED = 2'd1;
    localparam logic [1:0] OP_VERTICAL   = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_FREQUENCY = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_RATE      = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSION    = 8'd3;

    // Register values after reset.
    localparam logic [6:0]  AMPLITUDE_RESET      = 7'd16;
    localparam logic [15:0] LINE_FREQUENCY_RESET = 16'd1043;
    localparam logic [15:0] TIME_RATE_RESET      = 16'd1043;
    localparam logic [15:0] COMPRESSION_RESET    = 16'd4096;

    // 2*pi in Q2.30, used to build the sine table.
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Signed width of an unwrapped source coordinate: a compressed line is
    // below 2^12 and the offset stays within +/-127.
    localparam int unsigned COORD_W = 14;

    typedef struct packed {
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] frame_time;
        logic [1:0]  op;
    } sldag_in_t;

    typedef struct packed {
        logic [7:0]  source_x;
        logic [7:0]  source_y;
        logic [15:0] source_index;
        logic [15:0] dest_index;
    } sldag_out_t;

endpackage

// File: rtl/core/sine_line_distortion_address_gen_core.sv
// Top level of the sine line-distortion address generator pipeline.
//
// Each transfer on the s_ channel carries one destination pixel (x, y), a
// frame number and a distortion mode; each transfer on the m_ channel carries
// the source pixel to fetch for it, as column, line and linear address, plus
// the linear destination address. Every input item yields exactly one result.
// The cfg_ channel writes amplitude, line frequency, time rate and compression
// by index; it is always ready and should only be used while the pipeline is
// empty.
// The block is a five-stage pipeline: multiply, phase sum and table index,
// registered sine ROM read, amplitude multiply, offset and wrap. A result
// is offered on m_valid from the stage 5 register, and while m_ready is held
// high one item is taken every cycle. Each stage holds when the stage after
// it is full and stalled, so a stall on m_ready fills bubbles first and then
// pushes back on s_ready; nothing is lost or repeated.
// Reset clears all valid bits and loads the configuration reset values. The
// sine ROM is a constant table built at elaboration and needs no fill.
module sine_line_distortion_address_gen_core #(
    parameter int unsigned IMAGE_WIDTH     = 256,
    parameter int unsigned IMAGE_HEIGHT    = 256,
    parameter int unsigned SINE_TABLE_SIZE = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sldag_pkg::sldag_in_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sldag_pkg::sldag_out_t               m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sldag_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sldag_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sldag_pkg::*;

    localparam int unsigned XW = $clog2(IMAGE_WIDTH);
    localparam int unsigned KW = $clog2(SINE_TABLE_SIZE);
    localparam logic [7:0] PX_MASK = (IMAGE_WIDTH >= 256) ? 8'hFF : 8'(IMAGE_WIDTH - 1);
    localparam logic [7:0] PY_MASK = (IMAGE_HEIGHT >= 256) ? 8'hFF : 8'(IMAGE_HEIGHT - 1);
    localparam logic [COORD_W-1:0] SX_MASK = COORD_W'(IMAGE_WIDTH - 1);
    localparam logic [COORD_W-1:0] SY_MASK = COORD_W'(IMAGE_HEIGHT - 1);

    typedef logic signed [15:0] sine_rom_t [SINE_TABLE_SIZE];

    // Quarter-wave sine in Q14 by an odd Taylor series in Q2.30.
    function automatic logic signed [15:0] sine_quarter(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (r * TWO_PI_Q30) >> 16;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        sum = longint'((64'(sum) + 64'd32768) >> 16);
        if (sum > 16384) begin
            sum = 16384;
        end
        return 16'(sum);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t         rom;
        logic [63:0]       p;
        logic [63:0]       r;
        logic signed [15:0] v;
        for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
            p = ((64'(k) << 16) / SINE_TABLE_SIZE) & 64'hFFFF;
            r = p & 64'h3FFF;
            if (p[14]) begin
                r = 64'd16384 - r;
            end
            v = sine_quarter(r);
            rom[k] = p[15] ? -v : v;
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Configuration registers.
    logic [6:0]  amplitude_reg;
    logic [15:0] line_frequency_reg;
    logic [15:0] time_rate_reg;
    logic [15:0] compression_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplitude_reg      <= AMPLITUDE_RESET;
            line_frequency_reg <= LINE_FREQUENCY_RESET;
            time_rate_reg      <= TIME_RATE_RESET;
            compression_reg    <= COMPRESSION_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_AMPLITUDE:      amplitude_reg      <= cfg_data[6:0];
                REG_LINE_FREQUENCY: line_frequency_reg <= cfg_data;
                REG_TIME_RATE:      time_rate_reg      <= cfg_data;
                REG_COMPRESSION:    compression_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and the ready chain; a stage loads when it is empty
    // or when the stage after it is about to move on.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = !v5_reg || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Stage 1: wrap the coordinates and form the three products.
    logic [7:0]  x_in;
    logic [7:0]  y_in;
    logic [7:0]  x1_reg, x2_reg, x3_reg, x4_reg;
    logic [7:0]  y1_reg, y2_reg, y3_reg, y4_reg;
    logic [1:0]  op1_reg, op2_reg, op3_reg, op4_reg;
    logic [11:0] ycomp1_reg, ycomp2_reg, ycomp3_reg, ycomp4_reg;
    logic [15:0] yprod1_reg;
    logic [15:0] tprod1_reg;
    logic [23:0] ycomp_full;
    logic [31:0] yprod_full;
    logic [31:0] tprod_full;

    assign x_in       = s_data.pixel_x & PX_MASK;
    assign y_in       = s_data.pixel_y & PY_MASK;
    assign yprod_full = 32'(y_in) * 32'(line_frequency_reg);
    assign tprod_full = 32'(s_data.frame_time) * 32'(time_rate_reg);
    assign ycomp_full = 24'(y_in) * 24'(compression_reg);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            x1_reg     <= x_in;
            y1_reg     <= y_in;
            op1_reg    <= s_data.op;
            yprod1_reg <= yprod_full[15:0];
            tprod1_reg <= tprod_full[15:0];
            ycomp1_reg <= ycomp_full[23:12];
        end
    end

    // Stage 2: phase modulo one turn, then the table index from its top bits.
    logic [15:0]   phase;
    logic [31:0]   kprod;
    logic [KW-1:0] k2_reg;

    assign phase = yprod1_reg + tprod1_reg;
    assign kprod = 32'(phase) * 32'(SINE_TABLE_SIZE);

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            k2_reg     <= kprod[16 +: KW];
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            op2_reg    <= op1_reg;
            ycomp2_reg <= ycomp1_reg;
        end
    end

    // Stage 3: registered sine ROM read.
    logic signed [15:0] sine3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            sine3_reg  <= SINE_ROM[k2_reg];
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            op3_reg    <= op2_reg;
            ycomp3_reg <= ycomp2_reg;
        end
    end

    // Stage 4: scale the sine by the amplitude.
    logic signed [22:0] prod4_reg;
    logic signed [22:0] prod_next;

    assign prod_next = 23'(signed'({1'b0, amplitude_reg})) * 23'(sine3_reg);

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            prod4_reg  <= prod_next;
            x4_reg     <= x3_reg;
            y4_reg     <= y3_reg;
            op4_reg    <= op3_reg;
            ycomp4_reg <= ycomp3_reg;
        end
    end

    // Stage 5: offset truncated toward zero, mode select, wrap and addresses.
    logic signed [22:0]        prod_biased;
    logic signed [COORD_W-1:0] offset;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic [COORD_W-1:0]        ux;
    logic [COORD_W-1:0]        uy;
    logic [31:0]               src_addr;
    logic [31:0]               dst_addr;
    sldag_out_t                out_next;
    sldag_out_t                out_reg;

    always_comb begin
        // A negative product is biased so the arithmetic shift rounds toward zero.
        prod_biased = prod4_reg[22] ? (prod4_reg + 23'sd16383) : prod4_reg;
        offset      = COORD_W'(prod_biased >>> 14);
        sx          = signed'(COORD_W'(x4_reg));
        sy          = signed'(COORD_W'(y4_reg));
        case (op4_reg)
            OP_HORIZONTAL: sx = signed'(COORD_W'(x4_reg)) + offset;
            OP_INTERLACED: sx = y4_reg[0] ? signed'(COORD_W'(x4_reg)) + offset
                                          : signed'(COORD_W'(x4_reg)) - offset;
            OP_VERTICAL:   sy = signed'(COORD_W'(ycomp4_reg)) + offset;
            default: ;
        endcase
        ux       = unsigned'(sx) & SX_MASK;
        uy       = unsigned'(sy) & SY_MASK;
        src_addr = (32'(uy) << XW) + 32'(ux);
        dst_addr = (32'(y4_reg) << XW) + 32'(x4_reg);
        out_next.source_x     = ux[7:0];
        out_next.source_y     = uy[7:0];
        out_next.source_index = src_addr[15:0];
        out_next.dest_index   = dst_addr[15:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule
